>>> hw/rtl/ffp_pkg.sv
// Shared constants and types for the formaldehyde sensor frame parser.
// No dependencies; used by ffp_framer, ffp_level and the top level.
package ffp_pkg;

    // Frame marker bytes
    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] TYPE_POLLED = 8'h86;
    localparam logic [7:0] TYPE_UPLOAD = 8'h17;

    // Frame position codes (byte index within a nine-byte frame)
    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_HUNT       = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE       = 4'd1;
    localparam logic [POS_W-1:0] POS_BODY_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_KEEP_FIRST = 4'd4;
    localparam logic [POS_W-1:0] POS_BODY_LAST  = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK      = 4'd8;

    // Frame kind flag
    localparam logic KIND_POLLED = 1'b0;
    localparam logic KIND_UPLOAD = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT = 2'd2;

    // Register reset values (0.04, 0.08 and 0.2 in units of 0.0001)
    localparam logic [15:0] GOOD_LIMIT_RST = 16'd400;
    localparam logic [15:0] FAIR_LIMIT_RST = 16'd800;
    localparam logic [15:0] OVER_LIMIT_RST = 16'd2000;

    // Level codes
    localparam logic [1:0] LEVEL_GOOD     = 2'd0;
    localparam logic [1:0] LEVEL_FAIR     = 2'd1;
    localparam logic [1:0] LEVEL_EXCEEDED = 2'd2;
    localparam logic [1:0] LEVEL_SEVERE   = 2'd3;

    // Framer to top: outcome of one processed byte
    typedef struct packed {
        logic        done;    // this byte closed a frame
        logic        ok;      // checksum matched
        logic        kind;    // frame kind of the closed frame
        logic [15:0] conc;    // stored concentration after this byte
    } t_frame_res;

endpackage

>>> hw/rtl/ffp_framer.sv
// Frame tracker: header hunt, type check, running checksum and value capture.
// Depends on ffp_pkg.
module ffp_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    output ffp_pkg::t_frame_res  o_res
);

    logic [ffp_pkg::POS_W-1:0] r_pos;
    logic [ffp_pkg::POS_W-1:0] n_pos;
    logic [ffp_pkg::POS_W-1:0] w_pos;
    logic                      r_kind;
    logic                      n_kind;
    logic [7:0]                r_sum;
    logic [7:0]                n_sum;
    logic [15:0]               r_conc;
    logic [15:0]               n_conc;
    logic [7:0]                r_bytes [4];   // frame bytes 4 to 7
    logic                      w_keep;
    logic                      w_done;
    logic                      w_ok;

    // Positions beyond the check byte cannot arise; treat them as hunting
    assign w_pos  = (r_pos > ffp_pkg::POS_CHECK) ? ffp_pkg::POS_HUNT : r_pos;
    assign w_keep = (w_pos >= ffp_pkg::POS_KEEP_FIRST) && (w_pos <= ffp_pkg::POS_BODY_LAST);
    assign w_ok   = (8'(-r_sum) == i_byte);

    // Next-state decode per byte position
    always_comb begin
        n_pos  = r_pos;
        n_kind = r_kind;
        n_sum  = r_sum;
        n_conc = r_conc;
        w_done = 1'b0;
        unique case (w_pos) inside
            ffp_pkg::POS_HUNT: begin
                n_pos = (i_byte == ffp_pkg::HDR_BYTE) ? ffp_pkg::POS_TYPE : ffp_pkg::POS_HUNT;
            end
            ffp_pkg::POS_TYPE: begin
                if (i_byte == ffp_pkg::TYPE_POLLED) begin
                    n_kind = ffp_pkg::KIND_POLLED;
                    n_sum  = i_byte;
                    n_pos  = ffp_pkg::POS_BODY_FIRST;
                end else if (i_byte == ffp_pkg::TYPE_UPLOAD) begin
                    n_kind = ffp_pkg::KIND_UPLOAD;
                    n_sum  = i_byte;
                    n_pos  = ffp_pkg::POS_BODY_FIRST;
                end else begin
                    n_pos = ffp_pkg::POS_HUNT;
                end
            end
            [ffp_pkg::POS_BODY_FIRST:ffp_pkg::POS_BODY_LAST]: begin
                n_sum = r_sum + i_byte;
                n_pos = w_pos + 4'd1;
            end
            ffp_pkg::POS_CHECK: begin
                n_pos  = ffp_pkg::POS_HUNT;
                w_done = 1'b1;
                if (w_ok) begin
                    if (r_kind == ffp_pkg::KIND_POLLED) begin
                        n_conc = {r_bytes[2], r_bytes[3]};
                    end else begin
                        n_conc = {r_bytes[0], r_bytes[1]};
                    end
                end
            end
            default: begin
                n_pos = (i_byte == ffp_pkg::HDR_BYTE) ? ffp_pkg::POS_TYPE : ffp_pkg::POS_HUNT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= ffp_pkg::POS_HUNT;
            r_kind <= ffp_pkg::KIND_POLLED;
            r_sum  <= 8'd0;
            r_conc <= 16'd0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_kind <= n_kind;
            r_sum  <= n_sum;
            r_conc <= n_conc;
        end
    end

    // Value bytes, kept only where a concentration can come from
    always_ff @(posedge i_clk) begin
        if (i_en && w_keep) begin
            r_bytes[w_pos[1:0]] <= i_byte;
        end
    end

    assign o_res.done = w_done;
    assign o_res.ok   = w_ok;
    assign o_res.kind = r_kind;
    assign o_res.conc = n_conc;

endmodule

>>> hw/rtl/ffp_level.sv
// Four-band level of a concentration against three limits, tested in order.
// Depends on ffp_pkg.
module ffp_level (
    input  logic [15:0] i_conc,
    input  logic [15:0] i_good_limit,
    input  logic [15:0] i_fair_limit,
    input  logic [15:0] i_over_limit,
    output logic [1:0]  o_level
);

    // First limit that holds sets the band
    always_comb begin
        if (i_conc < i_good_limit) begin
            o_level = ffp_pkg::LEVEL_GOOD;
        end else if (i_conc < i_fair_limit) begin
            o_level = ffp_pkg::LEVEL_FAIR;
        end else if (i_conc < i_over_limit) begin
            o_level = ffp_pkg::LEVEL_EXCEEDED;
        end else begin
            o_level = ffp_pkg::LEVEL_SEVERE;
        end
    end

endmodule

>>> hw/rtl/formaldehyde_frame_parser.sv
// Formaldehyde sensor frame parser, top level.
// The checksum byte passes through the input register and then the result register before its result beat.
// Throughput: one byte beat per cycle; the input register stalls only while a
// result beat waits at the output register.
// Reset (synchronous, active low): hunting for a header, sum and concentration
// zero, limits 400 / 800 / 2000. Depends on ffp_pkg, ffp_framer, ffp_level.
module formaldehyde_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Frame results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] check_ok, [16:1] concentration, [18:17] level
    output logic [0:0]  m_axis_tuser,   // [0] frame_kind
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                r_good_limit;
    logic [15:0]         r_good_lim;
    logic [15:0]         r_fair_lim;
    logic [15:0]         r_over_lim;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    logic                r_out_ok;
    logic                r_out_kind;
    logic [15:0]         r_out_conc;
    logic [1:0]          r_out_level;
    logic                w_stall;
    logic                w_proc;
    logic [1:0]          w_level;
    ffp_pkg::t_frame_res w_res;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_lim <= ffp_pkg::GOOD_LIMIT_RST;
            r_fair_lim <= ffp_pkg::FAIR_LIMIT_RST;
            r_over_lim <= ffp_pkg::OVER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ffp_pkg::CFG_GOOD_LIMIT: r_good_lim <= i_cfg_data;
                ffp_pkg::CFG_FAIR_LIMIT: r_fair_lim <= i_cfg_data;
                ffp_pkg::CFG_OVER_LIMIT: r_over_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Marker registered from a write to the good-limit register; low otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_limit <= 1'b0;
        end else begin
            r_good_limit <= i_cfg_we && (i_cfg_index == ffp_pkg::CFG_GOOD_LIMIT);
        end
    end

    // Whole pipe holds while a result beat is refused
    assign w_stall       = r_out_valid && !m_axis_tready;
    assign s_axis_tready = !w_stall;
    assign w_proc        = r_in_valid && !w_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!w_stall) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    ffp_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    ffp_level u_level (
        .i_conc       (w_res.conc),
        .i_good_limit (r_good_lim),
        .i_fair_limit (r_fair_lim),
        .i_over_limit (r_over_lim),
        .o_level      (w_level)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_stall) begin
            r_out_valid <= w_proc && w_res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res.done) begin
            r_out_ok    <= w_res.ok;
            r_out_kind  <= w_res.kind;
            r_out_conc  <= w_res.conc;
            r_out_level <= w_level;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_level, r_out_conc, r_out_ok};
    assign m_axis_tuser  = r_out_kind;

    // A new result beat only follows a byte held in the input register
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(r_in_valid))
        else $error("result beat without a processed byte");

    // A byte in the input register is not dropped while the output stalls
    a_byte_kept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_stall) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending byte lost during stall");

    // Limit write strobe only follows a write to the first register
    a_cfg_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_good_limit |-> $past(i_cfg_we))
        else $error("limit write marker without a write");

endmodule

>>> test/ffp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the formaldehyde frame parser: watches the byte, result and
// register ports, predicts every result beat and compares it. Depends on ffp_pkg.
module ffp_checker
    import ffp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        ok;
        logic        kind;
        logic [15:0] conc;
        logic [1:0]  level;
    } t_report;

    // Results predicted but not yet seen on the result port
    t_report reports_due [$];

    // Own copy of the parser state and limits
    logic [POS_W-1:0] frame_pos;
    logic             kind_flag;
    logic [7:0]       byte_sum;
    logic [7:0]       byte_store [0:8];
    logic [15:0]      conc_held;
    logic [15:0]      good_lim;
    logic [15:0]      fair_lim;
    logic [15:0]      over_lim;
    int               fails = 0;

    // Bands tested in turn, first hit wins even with limits out of order
    function automatic logic [1:0] level_of(input logic [15:0] c);
        if (c < good_lim) return LEVEL_GOOD;
        if (c < fair_lim) return LEVEL_FAIR;
        if (c < over_lim) return LEVEL_EXCEEDED;
        return LEVEL_SEVERE;
    endfunction

    // Advance the frame hunt by one received byte
    task automatic take_byte(input logic [7:0] b);
        logic [POS_W-1:0] pos;
        logic [7:0]       want_chk;
        t_report          rep;
        pos = frame_pos;
        if (pos > POS_CHECK) pos = POS_HUNT;
        byte_store[pos] = b;
        if (pos == POS_HUNT) begin
            frame_pos = (b == HDR_BYTE) ? POS_TYPE : POS_HUNT;
        end else if (pos == POS_TYPE) begin
            // a bad type byte drops back to the hunt and is not a header
            if (b == TYPE_POLLED || b == TYPE_UPLOAD) begin
                kind_flag = (b == TYPE_UPLOAD) ? KIND_UPLOAD : KIND_POLLED;
                byte_sum  = b;
                frame_pos = POS_BODY_FIRST;
            end else begin
                frame_pos = POS_HUNT;
            end
        end else if (pos < POS_CHECK) begin
            byte_sum  = byte_sum + b;
            frame_pos = pos + 1'b1;
        end else begin
            frame_pos = POS_HUNT;
            want_chk  = 8'h00 - byte_sum;
            rep.ok    = (b == want_chk);
            // failed check keeps the old value
            if (rep.ok) begin
                if (kind_flag == KIND_POLLED)
                    conc_held = {byte_store[POS_BODY_LAST - 1'b1], byte_store[POS_BODY_LAST]};
                else
                    conc_held = {byte_store[POS_KEEP_FIRST], byte_store[POS_KEEP_FIRST + 1'b1]};
            end
            rep.kind  = kind_flag;
            rep.conc  = conc_held;
            rep.level = level_of(conc_held);
            reports_due.push_back(rep);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Match one result beat against the oldest prediction
    task automatic check_report();
        t_report want;
        if (reports_due.size() == 0) begin
            $display("%0t ns: result beat expected none got %h/%h", $time,
                     i_m_tdata, i_m_tuser);
            fails++;
        end else begin
            want = reports_due.pop_front();
            compare_field("check_ok", want.ok, i_m_tdata[0]);
            compare_field("concentration", want.conc, i_m_tdata[16:1]);
            compare_field("level", want.level, i_m_tdata[18:17]);
            compare_field("frame_kind", want.kind, i_m_tuser[0]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = POS_HUNT;
            kind_flag = KIND_POLLED;
            byte_sum  = 8'h00;
            conc_held = 16'h0000;
            good_lim  = GOOD_LIMIT_RST;
            fair_lim  = FAIR_LIMIT_RST;
            over_lim  = OVER_LIMIT_RST;
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GOOD_LIMIT: good_lim = i_cfg_data;
                    CFG_FAIR_LIMIT: fair_lim = i_cfg_data;
                    CFG_OVER_LIMIT: over_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) take_byte(i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_report();
        end
        o_fail_count <= fails;
        o_pending    <= reports_due.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench top for formaldehyde_frame_parser: clock, reset, byte and register
// stimulus, result back-pressure and the verdict. Depends on ffp_pkg, ffp_checker.
module tb;
    import ffp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int BYTE_TARGET = 1850;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef enum int { RX_FREE, RX_SPARSE, RX_STALLY } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'h0000;

    int fail_count;
    int reports_pending;

    // limits currently programmed, used to aim concentrations at band edges
    logic [15:0] lim_good = GOOD_LIMIT_RST;
    logic [15:0] lim_fair = FAIR_LIMIT_RST;
    logic [15:0] lim_over = OVER_LIMIT_RST;

    int burst_left = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;

    formaldehyde_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ffp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (reports_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result back-pressure: modes of free flow, sparse stalls and long stalls
    t_rx_mode rx_mode = RX_FREE;
    int rx_mode_left = 0;
    int rx_stall_left = 0;
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 300);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    m_axis_tready <= 1'b0;
                end else if ($urandom_range(0, 4) == 0) begin
                    rx_stall_left = $urandom_range(1, 20);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("formaldehyde_frame_parser: mismatch");
                $finish;
            end
        end
    end

    // One byte beat, sent in bursts with random gaps
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Whole nine-byte frame carrying conc, with a good or corrupted checksum
    task automatic send_frame(input logic kind, input logic [15:0] conc, input logic good);
        logic [7:0] body [1:7];
        logic [7:0] sum;
        logic [7:0] chk;
        int i;
        body[1] = (kind == KIND_UPLOAD) ? TYPE_UPLOAD : TYPE_POLLED;
        for (i = 2; i <= 7; i++) body[i] = 8'($urandom);
        if (kind == KIND_POLLED) {body[6], body[7]} = conc;
        else                     {body[4], body[5]} = conc;
        sum = 8'h00;
        for (i = 1; i <= 7; i++) sum = sum + body[i];
        chk = 8'h00 - sum;
        if (!good) chk = chk ^ 8'($urandom_range(1, 255));
        push_byte(HDR_BYTE);
        for (i = 1; i <= 7; i++) push_byte(body[i]);
        push_byte(chk);
        bytes_sent += 9;
    endtask

    // Mostly near a band edge, sometimes the extremes or anywhere
    function automatic logic [15:0] pick_conc();
        int sel;
        logic [15:0] edge_off;
        sel = $urandom_range(0, 9);
        edge_off = 16'($urandom_range(0, 2)) - 16'd1;
        case (sel)
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return lim_good + edge_off;
            4, 5:    return lim_fair + edge_off;
            6, 7:    return lim_over + edge_off;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stop sending and wait until every predicted result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // All three limits, plus a write to the unused index that must be ignored
    task automatic set_limits(input logic [15:0] g, input logic [15:0] f, input logic [15:0] o);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GOOD_LIMIT;
        i_cfg_data  <= g;
        @(posedge i_clk);
        i_cfg_index <= CFG_FAIR_LIMIT;
        i_cfg_data  <= f;
        @(posedge i_clk);
        i_cfg_index <= CFG_OVER_LIMIT;
        i_cfg_data  <= o;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_SPARE;
        i_cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim_good = g;
        lim_fair = f;
        lim_over = o;
    endtask

    // Random mix: mostly frames, some noise, bad types and cut-short frames
    task automatic random_traffic(input int target);
        int sel;
        int n;
        int k;
        logic [7:0] bad_type;
        while (bytes_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                send_frame(($urandom_range(0, 1) != 0) ? KIND_UPLOAD : KIND_POLLED,
                           pick_conc(), $urandom_range(0, 3) != 0);
            end else if (sel < 80) begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) push_byte(8'($urandom));
                bytes_sent += n;
            end else if (sel < 88) begin
                bad_type = 8'($urandom);
                if (bad_type == TYPE_POLLED || bad_type == TYPE_UPLOAD) bad_type = HDR_BYTE;
                push_byte(HDR_BYTE);
                push_byte(bad_type);
                bytes_sent += 2;
            end else begin
                n = $urandom_range(0, 5);
                push_byte(HDR_BYTE);
                push_byte(($urandom_range(0, 1) != 0) ? TYPE_UPLOAD : TYPE_POLLED);
                for (k = 0; k < n; k++) push_byte(8'($urandom));
                bytes_sent += 2 + n;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full-scale polled frame, zero upload with a bad checksum,
        // then a header followed by a header as type byte
        send_frame(KIND_POLLED, 16'hFFFF, 1'b1);
        send_frame(KIND_UPLOAD, 16'h0000, 1'b0);
        push_byte(8'h00);
        push_byte(HDR_BYTE);
        push_byte(HDR_BYTE);
        push_byte(TYPE_POLLED);
        bytes_sent += 4;
        drain();

        // Random phases, each under its own set of limits
        set_limits(GOOD_LIMIT_RST, FAIR_LIMIT_RST, OVER_LIMIT_RST);
        random_traffic(BYTE_TARGET * 1 / 6);
        drain();
        set_limits(16'h0000, 16'h0000, 16'h0000);
        random_traffic(BYTE_TARGET * 2 / 6);
        drain();
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_traffic(BYTE_TARGET * 3 / 6);
        drain();
        set_limits(16'd3000, 16'd100, 16'd50000);
        random_traffic(BYTE_TARGET * 4 / 6);
        drain();
        set_limits(16'($urandom), 16'($urandom), 16'($urandom));
        random_traffic(BYTE_TARGET * 5 / 6);
        drain();
        set_limits(16'd1, 16'd2, 16'hFFFE);
        random_traffic(BYTE_TARGET);
        drain();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && reports_pending == 0) begin
            $display("formaldehyde_frame_parser: match");
        end else begin
            $display("formaldehyde_frame_parser: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ffp_pkg.sv
hw/rtl/ffp_framer.sv
hw/rtl/ffp_level.sv
hw/rtl/formaldehyde_frame_parser.sv
test/ffp_checker.sv
test/tb.sv
